@@ rtl/dss_pkg.sv @@
// Shared types and constants for the two-stacks-in-one-store unit.
package dss_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_LOW  = 3'd0,
    OP_PUSH_HIGH = 3'd1,
    OP_POP_LOW   = 3'd2,
    OP_POP_HIGH  = 3'd3,
    OP_DUMP_LOW  = 3'd4,
    OP_DUMP_HIGH = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    load_in;
    logic    push_low;
    logic    push_high;
    logic    pop_low;
    logic    pop_high;
    logic    dump_low;
    logic    dump_high;
    logic    dump_read;
    logic    out_load;
    logic    out_mem;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic low_empty;
    logic high_empty;
    logic last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/dual_stack_shared_array_unit.sv @@
// Top level of the two-stacks-in-one-store unit.
// Push: input registered in IDLE, result loaded to the output in EXEC; then IDLE again.
// Pop: the store read in EXEC is registered and loaded into the output register in RESP.
// Dump: EXEC, then DUMP and RESP once per word; back to IDLE after the last word's beat.
// Any beat waits while the output register still holds a beat the sink has not taken.
// Reset clears both stack counts and the output valid; the store is not cleared.
module dual_stack_shared_array_unit import dss_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic signed [DataW-1:0]   s_axis_tdata_i,  // push_value
  input  logic        [OpW-1:0]     s_axis_tuser_i,  // operation
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic signed [DataW-1:0]   m_axis_tdata_o,  // data_word
  output logic        [StatusW-1:0] m_axis_tuser_o,  // status
  output logic                      m_axis_tlast_o
);

  cmd_t cmd;
  sts_t sts;

  dss_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  dss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

@@ rtl/dss_ctrl.sv @@
// Controller state machine that sequences pushes, pops and dumps.
module dss_ctrl import dss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.out_status = ST_OK;
    s_axis_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.op)
          OP_PUSH_LOW, OP_PUSH_HIGH: begin
            if (sts_i.out_free) begin
              cmd_o.out_load = 1'b1;
              if (sts_i.full) begin
                cmd_o.out_status = ST_FULL;
              end else begin
                cmd_o.push_low  = (sts_i.op == OP_PUSH_LOW);
                cmd_o.push_high = (sts_i.op == OP_PUSH_HIGH);
              end
              state_d = S_IDLE;
            end
          end
          OP_POP_LOW, OP_DUMP_LOW: begin
            if (sts_i.low_empty) begin
              if (sts_i.out_free) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
                state_d          = S_IDLE;
              end
            end else if (sts_i.op == OP_POP_LOW) begin
              cmd_o.pop_low = 1'b1;
              state_d       = S_RESP;
            end else begin
              cmd_o.dump_low = 1'b1;
              state_d        = S_DUMP;
            end
          end
          OP_POP_HIGH, OP_DUMP_HIGH: begin
            if (sts_i.high_empty) begin
              if (sts_i.out_free) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
                state_d          = S_IDLE;
              end
            end else if (sts_i.op == OP_POP_HIGH) begin
              cmd_o.pop_high = 1'b1;
              state_d        = S_RESP;
            end else begin
              cmd_o.dump_high = 1'b1;
              state_d         = S_DUMP;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_DUMP: begin
        cmd_o.dump_read = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_mem  = 1'b1;
          state_d        = sts_i.last ? S_IDLE : S_DUMP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/dss_datapath.sv @@
// Datapath with the shared store, both stack counts and the output register.
module dss_datapath import dss_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic signed [DataW-1:0]   s_axis_tdata_i,
  input  logic        [OpW-1:0]     s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic signed [DataW-1:0]   m_axis_tdata_o,
  output logic        [StatusW-1:0] m_axis_tuser_o,
  output logic                      m_axis_tlast_o,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC   = CW'(DEPTH);
  localparam logic [CW:0]   DepthSum = (CW + 1)'(DEPTH);
  localparam logic [AW-1:0] TopAddr  = AW'(DEPTH - 1);

  logic        [OpW-1:0]   op_q;
  logic signed [DataW-1:0] val_q;
  logic        [CW-1:0]    count_low_q, count_low_d;
  logic        [CW-1:0]    count_high_q, count_high_d;
  logic        [AW-1:0]    idx_q, end_q;
  logic                    last_q;
  logic signed [DataW-1:0] mem_q [DEPTH];
  logic signed [DataW-1:0] rd_data_q;

  logic                    out_valid_q;
  logic        [StatusW-1:0] out_status_q;
  logic signed [DataW-1:0] out_data_q;
  logic                    out_last_q;

  logic [CW:0]   sum;
  logic [CW-1:0] low_m1, high_base, high_next;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;

  assign sum       = {1'b0, count_low_q} + {1'b0, count_high_q};
  assign low_m1    = count_low_q - CW'(1);
  assign high_base = DepthC - count_high_q;
  assign high_next = high_base - CW'(1);

  assign we    = cmd_i.push_low | cmd_i.push_high;
  assign waddr = cmd_i.push_high ? high_next[AW-1:0] : count_low_q[AW-1:0];
  assign re    = cmd_i.pop_low | cmd_i.pop_high | cmd_i.dump_read;

  always_comb begin
    if (cmd_i.pop_low) begin
      raddr = low_m1[AW-1:0];
    end else if (cmd_i.pop_high) begin
      raddr = high_base[AW-1:0];
    end else begin
      raddr = idx_q;
    end
  end

  always_comb begin
    count_low_d  = count_low_q;
    count_high_d = count_high_q;
    if (cmd_i.push_low) begin
      count_low_d = count_low_q + CW'(1);
    end else if (cmd_i.pop_low) begin
      count_low_d = low_m1;
    end
    if (cmd_i.push_high) begin
      count_high_d = count_high_q + CW'(1);
    end else if (cmd_i.pop_high) begin
      count_high_d = count_high_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_low_q  <= '0;
      count_high_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      count_low_q  <= count_low_d;
      count_high_q <= count_high_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= s_axis_tuser_i;
      val_q <= s_axis_tdata_i;
    end
    if (cmd_i.dump_low) begin
      idx_q <= '0;
      end_q <= low_m1[AW-1:0];
    end else if (cmd_i.dump_high) begin
      idx_q <= high_base[AW-1:0];
      end_q <= TopAddr;
    end else if (cmd_i.dump_read) begin
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.pop_low || cmd_i.pop_high) begin
      last_q <= 1'b1;
    end else if (cmd_i.dump_read) begin
      last_q <= (idx_q == end_q);
    end
    if (we) begin
      mem_q[waddr] <= val_q;
    end
    if (re) begin
      rd_data_q <= mem_q[raddr];
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_data_q   <= cmd_i.out_mem ? rd_data_q : '0;
      out_last_q   <= cmd_i.out_mem ? last_q : 1'b1;
    end
  end

  assign sts_o.op         = op_e'(op_q);
  assign sts_o.full       = (sum >= DepthSum);
  assign sts_o.low_empty  = (count_low_q == '0);
  assign sts_o.high_empty = (count_high_q == '0);
  assign sts_o.last       = last_q;
  assign sts_o.out_free   = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum <= DepthSum)
    else $error("Stacks hold more words than the store has.");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push_low || cmd_i.push_high) |-> !sts_o.full)
    else $error("Push while the store is full.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("Output register loaded while a beat is still pending.");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_low |-> !sts_o.low_empty) and (cmd_i.pop_high |-> !sts_o.high_empty))
    else $error("Pop from an empty stack.");

endmodule
